>>> rtl/swbox_pkg.sv
// Shared constants and control types for the swept box slab test.
package swbox_pkg;

    localparam int NUM_AXES    = 3;
    localparam int PIPE_STAGES = 5;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z = 2'd2;

    // slab times are Q.24; the fraction output is Q1.16 taken from bits 24:8
    localparam int FRAC_BITS   = 24;
    localparam int ONE_Q24     = 1 << FRAC_BITS;
    localparam int FRAC_DROP   = 8;
    localparam int FRAC_W      = 17;
    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;
    localparam int OUT_TDATA_W = 24;

    // per-stage load enables
    typedef struct packed {
        logic en_off;
        logic en_mul;
        logic en_sat;
    } swbox_lane_ctl_t;

    typedef struct packed {
        logic en_sel;
        logic en_out;
    } swbox_merge_ctl_t;

endpackage

>>> rtl/swbox_lane.sv
// One axis lane: widened offsets, scaling by the reciprocal, saturation, near/far sort.
module swbox_lane
    import swbox_pkg::*;
#(
    parameter int COORD_WIDTH = 24,
    parameter int RECIP_WIDTH = 32
)
(
    input  logic                            clk,
    input  swbox_lane_ctl_t                 ctl,
    input  logic        [COORD_WIDTH-2:0]   extent,
    input  logic signed [COORD_WIDTH-1:0]   trace_origin,
    input  logic signed [RECIP_WIDTH-1:0]   recip_delta,
    input  logic signed [COORD_WIDTH-1:0]   box_min,
    input  logic signed [COORD_WIDTH-1:0]   box_max,
    output logic signed [2*COORD_WIDTH-1:0] t_near,
    output logic signed [2*COORD_WIDTH-1:0] t_far
);

    localparam int DW = COORD_WIDTH + 2;          // offset width, exact
    localparam int MW = DW + RECIP_WIDTH;         // exact product width
    localparam int PW = 2 * COORD_WIDTH;          // saturated slab time width
    localparam int XW = ((MW > PW) ? MW : PW) + 1;

    localparam logic signed [XW-1:0] LIM_X = {{(XW-PW+1){1'b0}}, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] LIM_P = {1'b0, {(PW-1){1'b1}}};

    logic signed [DW-1:0]          d0_reg, d0_next, d1_reg, d1_next;
    logic signed [RECIP_WIDTH-1:0] r_reg;
    logic signed [MW-1:0]          p0_reg, p0_next, p1_reg, p1_next;
    logic signed [PW-1:0]          tn_reg, tf_reg, s0, s1;

    function automatic logic signed [PW-1:0] sat_time(input logic signed [MW-1:0] p);
        logic signed [XW-1:0] px;
        px = {{(XW-MW){p[MW-1]}}, p};
        if (px > LIM_X)
            sat_time = LIM_P;
        else if (px < -LIM_X)
            sat_time = -LIM_P;
        else
            sat_time = px[PW-1:0];
    endfunction

    // box moved to the trace start and widened by the hull
    assign d0_next = $signed({{2{box_min[COORD_WIDTH-1]}}, box_min})
                   - $signed({{2{trace_origin[COORD_WIDTH-1]}}, trace_origin})
                   - $signed({3'b000, extent});
    assign d1_next = $signed({{2{box_max[COORD_WIDTH-1]}}, box_max})
                   - $signed({{2{trace_origin[COORD_WIDTH-1]}}, trace_origin})
                   + $signed({3'b000, extent});

    assign p0_next = d0_reg * r_reg;
    assign p1_next = d1_reg * r_reg;

    assign s0 = sat_time(p0_reg);
    assign s1 = sat_time(p1_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.en_off)
        begin
            d0_reg <= d0_next;
            d1_reg <= d1_next;
            r_reg  <= recip_delta;
        end
        if (ctl.en_mul)
        begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
        end
        if (ctl.en_sat)
        begin
            tn_reg <= (s0 < s1) ? s0 : s1;
            tf_reg <= (s0 < s1) ? s1 : s0;
        end
    end

    assign t_near = tn_reg;
    assign t_far  = tf_reg;

endmodule

>>> rtl/swbox_merge.sv
// Merge of the lane times: latest entry, earliest exit, clamp and hit decision.
module swbox_merge
    import swbox_pkg::*;
#(
    parameter int PROD_WIDTH = 48
)
(
    input  logic                           clk,
    input  swbox_merge_ctl_t               ctl,
    input  logic signed [PROD_WIDTH-1:0]   t_near [NUM_AXES],
    input  logic signed [PROD_WIDTH-1:0]   t_far  [NUM_AXES],
    output logic                           hit,
    output logic        [FRAC_W-1:0]       entry_frac
);

    localparam logic signed [PROD_WIDTH-1:0] ONE_P = PROD_WIDTH'(ONE_Q24);

    logic signed [PROD_WIDTH-1:0] entry_reg, entry_next, exit_reg, exit_next;
    logic signed [PROD_WIDTH-1:0] entry_c, exit_c;
    logic                         hit_reg, hit_next;
    logic        [FRAC_W-1:0]     frac_reg, frac_next;

    always_comb
    begin
        entry_next = t_near[0];
        exit_next  = t_far[0];
        for (int a = 1; a < NUM_AXES; a++)
        begin
            if (t_near[a] > entry_next)
                entry_next = t_near[a];
            if (t_far[a] < exit_next)
                exit_next = t_far[a];
        end
    end

    always_comb
    begin
        entry_c   = (entry_reg < 0) ? '0 : entry_reg;
        exit_c    = (exit_reg > ONE_P) ? ONE_P : exit_reg;
        hit_next  = (entry_c <= exit_c);
        frac_next = hit_next ? entry_c[FRAC_DROP +: FRAC_W] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_sel)
        begin
            entry_reg <= entry_next;
            exit_reg  <= exit_next;
        end
        if (ctl.en_out)
        begin
            hit_reg  <= hit_next;
            frac_reg <= frac_next;
        end
    end

    assign hit        = hit_reg;
    assign entry_frac = frac_reg;

endmodule

>>> rtl/swept_box_aabb_slab_test_top.sv
// Top level of the swept box versus box slab test.
//
//  channel   dir  handshake              payload (low bit up)
//  s_axis    in   tvalid/tready          trace_origin x,y,z; recip_delta x,y,z;
//                                        box_min x,y,z; box_max x,y,z
//  m_axis    out  tvalid/tready          hit; entry_frac; zero fill
//  cfg       in   cfg_wr_en              cfg_index selects extent x,y,z; cfg_data value
//
//  One item per cycle while the output is not stalled, through 5 register
//  stages (offset, multiply, saturate/sort per lane, then select and decide
//  in the merge); a result is offered from the last stage.
//  The multiplier stage of each lane sets the clock; one lane per axis.
//  Reset clears the stage valids and the extents.
//  Each stage moves when the one after it is empty or moving, so input is
//  taken while a result waits at the output as long as a stage is free.
module swept_box_aabb_slab_test_top
    import swbox_pkg::*;
#(
    parameter int COORD_WIDTH = 24,
    parameter int RECIP_WIDTH = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // trace_origin_x,y,z, recip_delta_x,y,z, box_min_x,y,z, box_max_x,y,z, zero fill
    input  logic [((9*COORD_WIDTH+3*RECIP_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // hit, entry_frac[16:0], zero fill
    output logic [OUT_TDATA_W-1:0]              m_axis_tdata,
    input  logic                                cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]                cfg_index,
    input  logic [COORD_WIDTH-2:0]              cfg_data
);

    localparam int PW      = 2 * COORD_WIDTH;
    localparam int OFF_INV = 3 * COORD_WIDTH;
    localparam int OFF_MIN = 3 * COORD_WIDTH + 3 * RECIP_WIDTH;
    localparam int OFF_MAX = 6 * COORD_WIDTH + 3 * RECIP_WIDTH;

    logic [PIPE_STAGES-1:0] v_reg, v_next, adv, load;
    logic [COORD_WIDTH-2:0] ext_reg [NUM_AXES];

    swbox_lane_ctl_t        lane_ctl;
    swbox_merge_ctl_t       merge_ctl;

    logic signed [PW-1:0]   t_near [NUM_AXES];
    logic signed [PW-1:0]   t_far  [NUM_AXES];
    logic                   hit;
    logic [FRAC_W-1:0]      entry_frac;

    // stage advance chain
    always_comb
    begin
        adv[PIPE_STAGES-1] = !v_reg[PIPE_STAGES-1] || m_axis_tready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--)
            adv[k] = !v_reg[k] || adv[k+1];
        v_next[0] = adv[0] ? s_axis_tvalid : v_reg[0];
        load[0]   = adv[0] && s_axis_tvalid;
        for (int k = 1; k < PIPE_STAGES; k++)
        begin
            v_next[k] = adv[k] ? v_reg[k-1] : v_reg[k];
            load[k]   = adv[k] && v_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
                ext_reg[a] <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_EXTENT_X: ext_reg[0] <= cfg_data;
                REG_EXTENT_Y: ext_reg[1] <= cfg_data;
                REG_EXTENT_Z: ext_reg[2] <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign lane_ctl.en_off  = load[0];
    assign lane_ctl.en_mul  = load[1];
    assign lane_ctl.en_sat  = load[2];
    assign merge_ctl.en_sel = load[3];
    assign merge_ctl.en_out = load[4];

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_lane
        swbox_lane #(
            .COORD_WIDTH (COORD_WIDTH),
            .RECIP_WIDTH (RECIP_WIDTH)
        ) u_lane (
            .clk          (clk),
            .ctl          (lane_ctl),
            .extent       (ext_reg[a]),
            .trace_origin ($signed(s_axis_tdata[a*COORD_WIDTH +: COORD_WIDTH])),
            .recip_delta  ($signed(s_axis_tdata[OFF_INV + a*RECIP_WIDTH +: RECIP_WIDTH])),
            .box_min      ($signed(s_axis_tdata[OFF_MIN + a*COORD_WIDTH +: COORD_WIDTH])),
            .box_max      ($signed(s_axis_tdata[OFF_MAX + a*COORD_WIDTH +: COORD_WIDTH])),
            .t_near       (t_near[a]),
            .t_far        (t_far[a])
        );
    end

    swbox_merge #(
        .PROD_WIDTH (PW)
    ) u_merge (
        .clk        (clk),
        .ctl        (merge_ctl),
        .t_near     (t_near),
        .t_far      (t_far),
        .hit        (hit),
        .entry_frac (entry_frac)
    );

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = v_reg[PIPE_STAGES-1];
    assign m_axis_tdata  = {{(OUT_TDATA_W-FRAC_W-1){1'b0}}, entry_frac, hit};

    // an empty output stage lets the whole pipe move
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[PIPE_STAGES-1] |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    a_miss_zero_fraction: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[FRAC_W:1] == '0)
        else $error("miss carries a nonzero fraction");

    a_fraction_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[FRAC_W:1] <= FRAC_ONE)
        else $error("hit fraction above one");

    a_accept_reaches_stage: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> v_reg[0])
        else $error("accepted item lost at first stage");

endmodule

>>> test/swept_box_aabb_slab_test_top_tb.sv
// Self-checking testbench for the swept box versus box slab test block.
module swept_box_aabb_slab_test_top_tb;
    import swbox_pkg::*;

    localparam int CW   = 24;
    localparam int RW   = 32;
    localparam int IN_W = ((9*CW+3*RW+7)/8)*8;
    localparam int EW   = CW-1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam longint SAT_LIM = 64'sh7FFF_FFFF_FFFF;
    localparam logic [EW-1:0] EXT_MAX = {EW{1'b1}};

    // one box test; x is index 0 and trace_origin sits in the lowest bits
    typedef struct packed {
        logic [2:0][CW-1:0] box_max;
        logic [2:0][CW-1:0] box_min;
        logic [2:0][RW-1:0] recip_delta;
        logic [2:0][CW-1:0] trace_origin;
    } slab_query_t;

    typedef struct packed {
        logic [FRAC_W-1:0] fraction;
        logic              hit;
    } slab_hit_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [EW-1:0]        cfg_data = '0;

    slab_query_t pending_q[$];
    slab_hit_t   result_q[$];
    slab_query_t in_flight;
    logic [EW-1:0] hull_extent [3];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_queued = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int hit_count = 0;
    int reg_writes = 0;
    int directed_count = 0;

    swept_box_aabb_slab_test_top #(
        .COORD_WIDTH(CW),
        .RECIP_WIDTH(RW)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("FAIL");
        $finish;
    end

    function automatic longint sat_q24(longint p);
        if (p > SAT_LIM)
            return SAT_LIM;
        if (p < -SAT_LIM)
            return -SAT_LIM;
        return p;
    endfunction

    function automatic slab_hit_t predict_hit(slab_query_t q);
        slab_hit_t res;
        longint s, r, lo, hi, e, t0, t1, tn, tf, entry, leave, frac;
        int a;
        entry = 0;
        leave = 0;
        for (a = 0; a < NUM_AXES; a++)
        begin
            s  = longint'($signed(q.trace_origin[a]));
            r  = longint'($signed(q.recip_delta[a]));
            lo = longint'($signed(q.box_min[a]));
            hi = longint'($signed(q.box_max[a]));
            e  = longint'(hull_extent[a]);
            t0 = sat_q24((lo - s - e) * r);
            t1 = sat_q24((hi - s + e) * r);
            tn = (t0 < t1) ? t0 : t1;
            tf = (t0 < t1) ? t1 : t0;
            if (a == 0 || tn > entry)
                entry = tn;
            if (a == 0 || tf < leave)
                leave = tf;
        end
        if (entry < 0)
            entry = 0;
        if (leave > ONE_Q24)
            leave = ONE_Q24;
        res.hit = (entry <= leave);
        frac = entry >>> FRAC_DROP;
        res.fraction = res.hit ? frac[FRAC_W-1:0] : '0;
        return res;
    endfunction

    // min, max, zero, minus one or anything, at width w
    function automatic logic [31:0] corner_value(int w);
        logic [31:0] v;
        v = 32'd1 << (w-1);
        case ($urandom_range(4))
            0: corner_value = v;
            1: corner_value = v - 1;
            2: corner_value = '0;
            3: corner_value = '1;
            default: corner_value = $urandom;
        endcase
    endfunction

    // mostly boxes placed along the sweep, the rest raw or corner noise
    function automatic slab_query_t random_query();
        slab_query_t q;
        int pick, fr, a, s, d, c, h, lo, hi, tmp;
        pick = $urandom_range(99);
        fr = $urandom_range(1536);
        for (a = 0; a < NUM_AXES; a++)
        begin
            if (pick < 20)
            begin
                q.trace_origin[a] = CW'($urandom);
                q.recip_delta[a]  = $urandom;
                q.box_min[a]      = CW'($urandom);
                q.box_max[a]      = CW'($urandom);
            end
            else if (pick < 32)
            begin
                q.trace_origin[a] = CW'(corner_value(CW));
                q.recip_delta[a]  = corner_value(RW);
                q.box_min[a]      = CW'(corner_value(CW));
                q.box_max[a]      = CW'(corner_value(CW));
            end
            else
            begin
                s = $urandom_range(32767);
                s = s - 16384;
                d = $urandom_range(8191);
                d = d - 4096;
                if ($urandom_range(9) == 0)
                    d = 0;
                if (d == 0)
                    q.recip_delta[a] = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                else
                    q.recip_delta[a] = RW'((1 << FRAC_BITS) / d);
                c = $urandom_range(511);
                c = s + (d * fr) / 1024 + c - 256;
                h = $urandom_range(1023);
                lo = c - h;
                hi = c + h;
                if ($urandom_range(9) == 0)
                begin
                    tmp = lo;
                    lo = hi;
                    hi = tmp;
                end
                q.trace_origin[a] = CW'(s);
                q.box_min[a]      = CW'(lo);
                q.box_max[a]      = CW'(hi);
            end
        end
        return q;
    endfunction

    // axes that place no limit on the sweep
    function automatic slab_query_t open_query();
        slab_query_t q;
        int a;
        for (a = 0; a < NUM_AXES; a++)
        begin
            q.trace_origin[a] = '0;
            q.recip_delta[a]  = 32'h7FFF_FFFF;
            q.box_min[a]      = CW'(-256);
            q.box_max[a]      = CW'(256);
        end
        return q;
    endfunction

    task automatic push_query(slab_query_t q);
        pending_q.push_back(q);
        items_queued++;
    endtask

    task automatic push_random(int n);
        repeat (n)
            push_query(random_query());
    endtask

    task automatic wait_drained();
        while (results_checked != items_queued)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [EW-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_EXTENT_X: hull_extent[0] = val;
            REG_EXTENT_Y: hull_extent[1] = val;
            REG_EXTENT_Z: hull_extent[2] = val;
            default: ;
        endcase
        reg_writes++;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic note_mismatch(string what, slab_hit_t exp, logic [OUT_TDATA_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch (%s): expected hit=%0d frac=%0d, got hit=%0d frac=%0d",
                     what, exp.hit, exp.fraction, got[0], got[FRAC_W:1]);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                result_q.push_back(predict_hit(in_flight));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_flight = pending_q.pop_front();
                    s_axis_tdata  <= in_flight;
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        slab_hit_t exp;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (result_q.size() == 0)
                begin
                    exp = '0;
                    note_mismatch("item with nothing expected", exp, m_axis_tdata);
                end
                else
                begin
                    exp = result_q.pop_front();
                    results_checked++;
                    if (exp.hit)
                        hit_count++;
                    if (m_axis_tdata[0] !== exp.hit)
                        note_mismatch("hit", exp, m_axis_tdata);
                    else if (m_axis_tdata[FRAC_W:1] !== exp.fraction)
                        note_mismatch("entry_frac", exp, m_axis_tdata);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        slab_query_t q;
        int guard;
        hull_extent[0] = '0;
        hull_extent[1] = '0;
        hull_extent[2] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 25;
        recv_idle_pct = 51;

        // directed part, extents still at reset
        push_query('0);            // zero reciprocals everywhere
        push_query('1);
        q = '0;
        q.trace_origin = {3{24'h7F_FFFF}};
        q.recip_delta  = {3{32'h7FFF_FFFF}};
        q.box_min      = {3{24'h80_0000}};
        q.box_max      = {3{24'h7F_FFFF}};
        push_query(q);             // saturating negative product
        q.trace_origin = {3{24'h80_0000}};
        q.recip_delta  = {3{32'h8000_0000}};
        q.box_min      = {3{24'h7F_FFFF}};
        push_query(q);             // both times saturate negative, miss
        q.recip_delta = {3{32'h7FFF_FFFF}};
        push_query(q);             // both saturate positive, miss
        q = open_query();
        push_query(q);             // start inside, open on all axes
        q.recip_delta[0] = 65536;
        q.box_min[0] = CW'(256);
        q.box_max[0] = CW'(512);
        push_query(q);             // entry exactly at the end of the sweep
        q.box_min[0] = CW'(257);
        push_query(q);             // just past the end
        q.box_min[0] = CW'(128);
        push_query(q);             // halfway
        q.box_min[0] = CW'(512);
        q.box_max[0] = CW'(128);
        push_query(q);             // swapped corners
        q.recip_delta[0] = 32'hFFFF_0000;
        q.box_min[0] = CW'(-128);
        q.box_max[0] = CW'(-64);
        push_query(q);             // negative sweep
        q.recip_delta[0] = 65536;
        q.box_min[0] = CW'(-512);
        q.box_max[0] = CW'(-256);
        push_query(q);             // box behind the start
        q.recip_delta[0] = '0;
        q.box_min[0] = CW'(256);
        q.box_max[0] = CW'(512);
        push_query(q);             // zero reciprocal, start outside
        q.box_min[0] = CW'(64);
        q.recip_delta[0] = 65536;
        q.recip_delta[1] = 65536;
        q.box_min[1] = CW'(192);
        q.box_max[1] = CW'(512);
        push_query(q);             // entry set by y
        q = open_query();
        q.recip_delta[2] = 65537;
        q.box_min[2] = CW'(100);
        q.box_max[2] = CW'(400);
        push_query(q);             // low bits dropped from the fraction
        q.trace_origin[2] = 24'h80_0000;
        q.recip_delta[2]  = 32'h7FFF_FFFF;
        q.box_min[2] = 24'h7F_FFFF;
        q.box_max[2] = 24'h7F_FFFF;
        push_query(q);             // overflow on one axis only
        push_random(4);
        directed_count = items_queued;
        wait_drained();

        write_reg(REG_EXTENT_X, EXT_MAX);
        write_reg(REG_EXTENT_Y, '0);
        write_reg(REG_EXTENT_Z, EW'($urandom_range(2047)));
        write_reg(REG_UNUSED, EW'($urandom));
        push_random(100);
        // sender holds until the pipe is empty, then carries on
        wait_drained();
        push_random(100);
        wait_drained();

        send_idle_pct = 51;
        recv_idle_pct = 25;
        write_reg(REG_EXTENT_X, EW'($urandom_range(2047)));
        write_reg(REG_EXTENT_Y, EXT_MAX);
        write_reg(REG_EXTENT_Z, EXT_MAX);
        write_reg(REG_UNUSED, EW'($urandom));
        push_random(150);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_EXTENT_X, EW'($urandom_range(8191)));
        write_reg(REG_EXTENT_Y, EW'($urandom_range(2047)));
        write_reg(REG_EXTENT_Z, EW'($urandom_range(511)));
        write_reg(REG_UNUSED, EW'($urandom));
        push_random(150);

        guard = 0;
        while (results_checked != items_queued && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (PIPE_STAGES * 4) @(posedge clk);
        if (results_checked != items_queued)
            $display("%0d results never arrived", items_queued - results_checked);

        $display("ran %0d box tests (%0d directed), %0d hits, %0d register writes",
                 items_queued, directed_count, hit_count, reg_writes);
        $display("%0d mismatches over three idle patterns and four extent settings",
                 mismatch_count);
        if (mismatch_count == 0 && results_checked == items_queued)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
